>>> rtl/core/ldre_pkg.sv
// Shared types and constants for the link delivery ratio estimator.
// Used by every module under rtl/core but ldre_ram; depends on nothing.
package ldre_pkg;

  localparam int MAX_PEERS   = 64;
  localparam int PEER_AW     = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int SUM_W       = 10;
  localparam int RATIO_W     = 16;
  localparam int DIV_CW      = $clog2(RATIO_W + 1);
  localparam int GAP_LIMIT   = 200;
  localparam int HALVE_ABOVE = 400;
  localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};

  localparam logic KIND_BEACON = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [5:0]  source_index;
    logic [31:0] sequence_req;
    logic [31:0] arrival_time;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         peer_index;
    logic               ratio_updated;
    logic [RATIO_W-1:0] delivery_ratio;
    logic [31:0]        beacon_total;
    logic [31:0]        data_total;
  } out_item_t;

  // One word of per-peer state as it is kept in the state memory.
  typedef struct packed {
    logic [31:0]        heard_time;
    logic [RATIO_W-1:0] ratio_store;
    logic [31:0]        prev_sequence;
    logic [SUM_W-1:0]   expected_sum;
    logic [SUM_W-1:0]   received_sum;
    logic [31:0]        beacon_count;
  } peer_entry_t;

  localparam int ENTRY_W = $bits(peer_entry_t);

  typedef struct packed {
    logic               done;
    logic [RATIO_W-1:0] quotient;
  } div_res_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

endpackage

>>> rtl/core/ldre_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No package dependency.
module ldre_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/ldre_div.sv
// Iterative restoring divider producing received/expected as unsigned Q0.16.
// Depends on ldre_pkg. One quotient bit per cycle.
module ldre_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ldre_pkg::SUM_W-1:0]    num,
  input  logic [ldre_pkg::SUM_W-1:0]    den,
  output ldre_pkg::div_res_t            res
);

  logic                           busy_r;
  logic                           done_r;
  logic [ldre_pkg::DIV_CW-1:0]    cnt_r;
  logic [ldre_pkg::SUM_W-1:0]     rem_r;
  logic [ldre_pkg::SUM_W-1:0]     den_r;
  logic [ldre_pkg::RATIO_W-1:0]   quot_r;

  logic [ldre_pkg::SUM_W:0]       shifted;
  logic                           ge;
  logic [ldre_pkg::SUM_W:0]       diff;

  assign shifted = {rem_r, 1'b0};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      // A numerator that is not below the divisor gives a ratio of one or
      // more, which saturates.
      if (num >= den) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
      end
      cnt_r <= ldre_pkg::DIV_CW'(ldre_pkg::RATIO_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == ldre_pkg::DIV_CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r  <= den;
      rem_r  <= num;
      quot_r <= (num >= den) ? ldre_pkg::RATIO_MAX : '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[ldre_pkg::SUM_W-1:0] : shifted[ldre_pkg::SUM_W-1:0];
      quot_r <= {quot_r[ldre_pkg::RATIO_W-2:0], ge};
    end
  end

  assign res.done     = done_r;
  assign res.quotient = quot_r;

endmodule

>>> rtl/core/link_delivery_ratio_estimator.sv
// Top level of the link delivery ratio estimator: sequencer, per-peer state
// memory and output register. Depends on ldre_pkg, ldre_ram and ldre_div.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_stall    ldre_pkg::in_item_t
//   out_      output     out_valid / out_stall  ldre_pkg::out_item_t
//   cfg_      input      cfg_valid / cfg_ready  cfg_data (estimate enable)
//
// An updating beacon passes from the read step through the 16-step divider to the
// finish step; one whose two sums are equal saturates at once. Any other frame goes
// from the read step, where the registered state memory data arrives, to finish.
// Reset (rst_n low, synchronous) clears the known-sequence valid bits, the data
// counter and the enable, which makes every peer read as all zero.
// An output stall holds the finish step while the previous result waits unsent.
module link_delivery_ratio_estimator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ldre_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ldre_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);

  ldre_pkg::state_t state_r, state_nxt;

  logic                           enable_r;
  logic [ldre_pkg::MAX_PEERS-1:0] known_r;
  logic [31:0]                    data_count_r;
  logic                           out_valid_r;
  ldre_pkg::out_item_t            out_data_r;
  logic                           start_r;

  // Per-item working registers.
  ldre_pkg::in_item_t             item_r;
  logic [ldre_pkg::PEER_AW-1:0]   idx_r;
  logic                           peer_ok_r;
  ldre_pkg::peer_entry_t          entry_r, entry_nxt;
  logic                           upd_r, upd_nxt;
  logic [ldre_pkg::RATIO_W-1:0]   ratio_r;

  logic                           accept;
  logic                           out_free;
  logic                           finish;
  logic [ldre_pkg::ENTRY_W-1:0]   ram_rd;
  ldre_pkg::peer_entry_t          cur;
  logic                           known_cur;
  logic [31:0]                    gap;
  logic                           gap_ok;
  logic [ldre_pkg::SUM_W:0]       exp_sum;
  logic [ldre_pkg::SUM_W:0]       rec_sum;
  ldre_pkg::div_res_t             div_res;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ldre_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign finish    = (state_r == ldre_pkg::ST_FIN) && out_free;

  // The memory is read when the frame is taken in and written back once, in
  // the finish step. Input is stalled from the read until that write has
  // happened, so a following frame to the same peer always sees fresh data.
  ldre_ram #(
    .DEPTH (ldre_pkg::MAX_PEERS),
    .WIDTH (ldre_pkg::ENTRY_W),
    .AW    (ldre_pkg::PEER_AW)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (finish && peer_ok_r),
    .wr_addr (idx_r),
    .wr_data (entry_r),
    .rd_en   (accept),
    .rd_addr (ldre_pkg::PEER_AW'(in_data.source_index)),
    .rd_data (ram_rd)
  );

  ldre_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .num   (entry_r.received_sum),
    .den   (entry_r.expected_sum),
    .res   (div_res)
  );

  // A peer that has never sent a beacon has no valid entry; it reads as zero.
  assign known_cur = peer_ok_r && known_r[idx_r];
  assign cur       = known_cur ? ldre_pkg::peer_entry_t'(ram_rd) : '0;
  assign gap       = item_r.sequence_req - cur.prev_sequence;
  assign gap_ok    = (item_r.sequence_req > cur.prev_sequence) &&
                     (gap < 32'(ldre_pkg::GAP_LIMIT));
  assign exp_sum   = {1'b0, cur.expected_sum} + (ldre_pkg::SUM_W + 1)'(gap[7:0]);
  assign rec_sum   = {1'b0, cur.received_sum} + 1'b1;

  // Peer entry update, worked out in the cycle the read data arrives, plus the ratio once the divide is done.
  always_comb begin
    entry_nxt = entry_r;
    upd_nxt   = upd_r;
    if (state_r == ldre_pkg::ST_READ) begin
      entry_nxt            = cur;
      entry_nxt.heard_time = item_r.arrival_time;
      upd_nxt              = 1'b0;
      if (item_r.kind == ldre_pkg::KIND_BEACON) begin
        entry_nxt.beacon_count  = cur.beacon_count + 32'd1;
        entry_nxt.prev_sequence = item_r.sequence_req;
        if (known_cur && enable_r && gap_ok) begin
          upd_nxt = 1'b1;
          // Both sums are halved together once the expected sum passes the
          // window limit, which keeps the ratio and bounds the widths.
          if (exp_sum > (ldre_pkg::SUM_W + 1)'(ldre_pkg::HALVE_ABOVE)) begin
            entry_nxt.expected_sum = exp_sum[ldre_pkg::SUM_W:1];
            entry_nxt.received_sum = rec_sum[ldre_pkg::SUM_W:1];
          end else begin
            entry_nxt.expected_sum = exp_sum[ldre_pkg::SUM_W-1:0];
            entry_nxt.received_sum = rec_sum[ldre_pkg::SUM_W-1:0];
          end
        end
      end
    end else if ((state_r == ldre_pkg::ST_DIV) && div_res.done) begin
      entry_nxt.ratio_store = div_res.quotient;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ldre_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = ldre_pkg::ST_READ;
        end
      end
      ldre_pkg::ST_READ: begin
        state_nxt = upd_nxt ? ldre_pkg::ST_DIV : ldre_pkg::ST_FIN;
      end
      ldre_pkg::ST_DIV: begin
        if (div_res.done && !start_r) begin
          state_nxt = ldre_pkg::ST_FIN;
        end
      end
      ldre_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = ldre_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ldre_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ldre_pkg::ST_IDLE;
      enable_r     <= 1'b0;
      known_r      <= '0;
      data_count_r <= '0;
      out_valid_r  <= 1'b0;
      start_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= (state_r == ldre_pkg::ST_READ) && upd_nxt;
      if (cfg_valid && cfg_ready) begin
        enable_r <= cfg_data;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
        if (item_r.kind == ldre_pkg::KIND_DATA) begin
          data_count_r <= data_count_r + 32'd1;
        end
        if (peer_ok_r && (item_r.kind == ldre_pkg::KIND_BEACON)) begin
          known_r[idx_r] <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r    <= in_data;
      idx_r     <= ldre_pkg::PEER_AW'(in_data.source_index);
      peer_ok_r <= 32'(in_data.source_index) < ldre_pkg::MAX_PEERS;
    end
    entry_r <= entry_nxt;
    upd_r   <= upd_nxt;
    if ((state_r == ldre_pkg::ST_DIV) && div_res.done) begin
      ratio_r <= div_res.quotient;
    end
    if (finish) begin
      out_data_r.peer_index     <= item_r.source_index;
      out_data_r.ratio_updated  <= upd_r;
      out_data_r.delivery_ratio <= upd_r ? ratio_r : '0;
      out_data_r.beacon_total   <= peer_ok_r ? entry_r.beacon_count : 32'd0;
      out_data_r.data_total     <= (item_r.kind == ldre_pkg::KIND_DATA) ?
                                   data_count_r + 32'd1 : data_count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/ldre_chk.sv
// Port-level checker for the link delivery ratio estimator, bound to the top.
// Depends on ldre_pkg.
module ldre_chk (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  ldre_pkg::out_item_t  out_data
);

  // A taken frame is worked on alone, so input stalls right after a transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transfer");

  // A result without a new ratio carries a zero ratio.
  a_ratio_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ratio_updated |-> out_data.delivery_ratio == '0)
    else $error("ratio nonzero without an update");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // The data total rises by at most one between two successive results.
  a_data_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall ##1 out_valid && !$stable(out_data) |->
      out_data.data_total - $past(out_data.data_total) <= 32'd1)
    else $error("data total jumped");

endmodule

bind link_delivery_ratio_estimator ldre_chk u_ldre_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> dv/link_delivery_ratio_estimator_tb.sv
// Self-checking testbench for link_delivery_ratio_estimator: directed frame table, then random
// beacon/data traffic under varying back-pressure, all checked against an in-bench estimator.
// Depends on ldre_pkg and the RTL under rtl/core only.
module link_delivery_ratio_estimator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic { ROW_FRAME, ROW_ENABLE } row_op_t;

  // One line of the directed table: either a frame transfer or an enable write.
  // When typed is set, the expected report is the one written in the row.
  typedef struct {
    row_op_t             op;
    logic                typed;
    logic                enable;
    ldre_pkg::in_item_t  frame;
    ldre_pkg::out_item_t want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ldre_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ldre_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_data = 1'b0;

  // Estimator state kept by the bench, at the block's widths.
  logic                       est_enable;
  logic                       seq_seen    [ldre_pkg::MAX_PEERS];
  logic [31:0]                last_seq    [ldre_pkg::MAX_PEERS];
  logic [ldre_pkg::SUM_W-1:0] expect_sum  [ldre_pkg::MAX_PEERS];
  logic [ldre_pkg::SUM_W-1:0] receive_sum [ldre_pkg::MAX_PEERS];
  logic [31:0]                beacon_cnt  [ldre_pkg::MAX_PEERS];
  logic [31:0]                data_cnt;

  // Last beacon sequence sent per source, used to build well-formed gaps.
  logic [31:0] sent_seq [ldre_pkg::MAX_PEERS];

  ldre_pkg::out_item_t ratio_reports [$];
  int        mismatch_count = 0;
  int        send_gap_pct = 0;
  int        recv_stall_pct = 0;

  link_delivery_ratio_estimator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Computes the report for one accepted frame and advances the estimator state.
  function automatic ldre_pkg::out_item_t estimate_link(input ldre_pkg::in_item_t f);
    ldre_pkg::out_item_t rep;
    logic [31:0] gap;
    logic [31:0] e_next;
    logic [31:0] r_next;
    logic [31:0] quo;
    rep = '0;
    rep.peer_index = f.source_index;
    if (f.kind == ldre_pkg::KIND_DATA) begin
      data_cnt = data_cnt + 1;
    end
    if (int'(f.source_index) < ldre_pkg::MAX_PEERS) begin
      if (f.kind == ldre_pkg::KIND_BEACON) begin
        beacon_cnt[f.source_index] = beacon_cnt[f.source_index] + 1;
        gap = f.sequence_req - last_seq[f.source_index];
        // Only a forward gap below the limit moves the sums.
        if (seq_seen[f.source_index] && est_enable &&
            f.sequence_req > last_seq[f.source_index] && gap < ldre_pkg::GAP_LIMIT) begin
          e_next = 32'(expect_sum[f.source_index]) + gap;
          r_next = 32'(receive_sum[f.source_index]) + 1;
          if (e_next > ldre_pkg::HALVE_ABOVE) begin
            e_next = e_next >> 1;
            r_next = r_next >> 1;
          end
          expect_sum[f.source_index]  = e_next[ldre_pkg::SUM_W-1:0];
          receive_sum[f.source_index] = r_next[ldre_pkg::SUM_W-1:0];
          quo = (r_next << ldre_pkg::RATIO_W) / e_next;
          rep.ratio_updated  = 1'b1;
          rep.delivery_ratio = (quo > 32'(ldre_pkg::RATIO_MAX)) ? ldre_pkg::RATIO_MAX :
                                                                  quo[ldre_pkg::RATIO_W-1:0];
        end
        last_seq[f.source_index] = f.sequence_req;
        seq_seen[f.source_index] = 1'b1;
      end
      rep.beacon_total = beacon_cnt[f.source_index];
    end
    rep.data_total = data_cnt;
    return rep;
  endfunction

  // Offers one frame, waits for its transfer and records the report it must produce.
  task automatic send_frame(input ldre_pkg::in_item_t f, input logic typed,
                            input ldre_pkg::out_item_t want);
    ldre_pkg::out_item_t rep;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rep = estimate_link(f);
    ratio_reports.push_back(typed ? want : rep);
  endtask

  // Drops valid and holds off until every outstanding report has come back.
  task automatic drain_reports();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ratio_reports.size() != 0) @(posedge clk);
  endtask

  // Enable writes happen only with the block idle.
  task automatic write_enable(input logic value);
    drain_reports();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    est_enable = value;
  endtask

  // Random traffic: mostly beacons from a few busy peers with small forward
  // gaps, so the sums fill up and get halved, mixed with large gaps,
  // backward steps, wrapped sequences, fully random numbers and data frames.
  task automatic run_traffic(input int frames, input logic enable, input int gap_pct,
                             input int stall_pct);
    ldre_pkg::in_item_t f;
    int       pick;
    write_enable(enable);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    repeat (frames) begin
      if ($urandom_range(0, 199) == 0) begin
        drain_reports();
      end
      f.source_index = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, 3)) :
                                                     6'($urandom_range(0, 63));
      f.kind         = ($urandom_range(0, 9) < 2) ? ldre_pkg::KIND_DATA :
                                                    ldre_pkg::KIND_BEACON;
      f.arrival_time = $urandom;
      pick = $urandom_range(0, 99);
      if (f.kind == ldre_pkg::KIND_DATA || pick >= 95) begin
        f.sequence_req = $urandom;
      end else if (pick < 65) begin
        f.sequence_req = sent_seq[f.source_index] + $urandom_range(1, 8);
      end else if (pick < 75) begin
        f.sequence_req = sent_seq[f.source_index] + $urandom_range(9, 199);
      end else if (pick < 83) begin
        f.sequence_req = sent_seq[f.source_index] + $urandom_range(200, 400);
      end else if (pick < 90) begin
        f.sequence_req = sent_seq[f.source_index] - $urandom_range(0, 50);
      end else begin
        // Just below the wrap point, so the next small gaps cross zero.
        f.sequence_req = 32'hFFFF_FF00 + $urandom_range(0, 255);
      end
      if (f.kind == ldre_pkg::KIND_BEACON) begin
        sent_seq[f.source_index] = f.sequence_req;
      end
      send_frame(f, 1'b0, '0);
    end
  endtask

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // Every result transfer is matched against the oldest outstanding report.
  always @(posedge clk) begin
    ldre_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (ratio_reports.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected report for peer %0d, expected none, got %0h",
                 $time, out_data.peer_index, out_data);
      end else begin
        want = ratio_reports.pop_front();
        compare_field("peer_index", 32'(want.peer_index), 32'(out_data.peer_index));
        compare_field("ratio_updated", 32'(want.ratio_updated), 32'(out_data.ratio_updated));
        compare_field("delivery_ratio", 32'(want.delivery_ratio),
                      32'(out_data.delivery_ratio));
        compare_field("beacon_total", want.beacon_total, out_data.beacon_total);
        compare_field("data_total", want.data_total, out_data.data_total);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    dir_row_t            dir_table [$];
    ldre_pkg::in_item_t  no_frame;
    ldre_pkg::out_item_t no_report;
    no_frame  = '0;
    no_report = '0;
    est_enable = 1'b0;
    data_cnt   = '0;
    for (int i = 0; i < ldre_pkg::MAX_PEERS; i++) begin
      seq_seen[i]    = 1'b0;
      last_seq[i]    = '0;
      expect_sum[i]  = '0;
      receive_sum[i] = '0;
      beacon_cnt[i]  = '0;
      sent_seq[i]    = '0;
    end

    // Estimation off: counters move, the sequence is learned, no ratio.
    dir_table.push_back('{ROW_ENABLE, 1'b0, 1'b0, no_frame, no_report});
    dir_table.push_back('{ROW_FRAME, 1'b1, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd0, 32'd100, 32'd0},
      ldre_pkg::out_item_t'{6'd0, 1'b0, 16'd0, 32'd1, 32'd0}});
    dir_table.push_back('{ROW_FRAME, 1'b1, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_DATA, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      ldre_pkg::out_item_t'{6'd63, 1'b0, 16'd0, 32'd0, 32'd1}});
    dir_table.push_back('{ROW_FRAME, 1'b1, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd0, 32'd101, 32'd5},
      ldre_pkg::out_item_t'{6'd0, 1'b0, 16'd0, 32'd2, 32'd1}});
    // Estimation on. A gap of one with nothing lost saturates the ratio.
    dir_table.push_back('{ROW_ENABLE, 1'b0, 1'b1, no_frame, no_report});
    dir_table.push_back('{ROW_FRAME, 1'b1, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd0, 32'd102, 32'd6},
      ldre_pkg::out_item_t'{6'd0, 1'b1, ldre_pkg::RATIO_MAX, 32'd3, 32'd1}});
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd0, 32'd104, 32'd7}, no_report});
    // Equal and backward sequences leave the sums alone.
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd0, 32'd104, 32'd8}, no_report});
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd0, 32'd50, 32'd9}, no_report});
    // Largest accepted gap, then the first rejected one.
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd0, 32'd249, 32'd10}, no_report});
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd0, 32'd449, 32'd11}, no_report});
    // This gap pushes the expected sum past the limit, so both sums halve.
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd0, 32'd648, 32'd12}, no_report});
    // A data frame leaves the sequence and ratio state untouched.
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_DATA, 6'd0, 32'd0, 32'd13}, no_report});
    // Sequence wrapping from all ones to zero counts as a backward step.
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd1, 32'hFFFF_FFFF, 32'd14}, no_report});
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd1, 32'd0, 32'd15}, no_report});
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd1, 32'd199, 32'd16}, no_report});
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd63, 32'hFFFF_FF38, 32'hFFFF_FFFF},
      no_report});
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd63, 32'hFFFF_FFFF, 32'h0}, no_report});
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd2, 32'h8000_0000, 32'h8000_0000},
      no_report});
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_DATA, 6'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      no_report});
    // Disabled again: the sequence still advances and is remembered.
    dir_table.push_back('{ROW_ENABLE, 1'b0, 1'b0, no_frame, no_report});
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd0, 32'd649, 32'd20}, no_report});
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd0, 32'd650, 32'd21}, no_report});
    dir_table.push_back('{ROW_ENABLE, 1'b0, 1'b1, no_frame, no_report});
    dir_table.push_back('{ROW_FRAME, 1'b0, 1'b0,
      ldre_pkg::in_item_t'{ldre_pkg::KIND_BEACON, 6'd0, 32'd651, 32'd22}, no_report});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct   = 24;
    recv_stall_pct = 84;
    foreach (dir_table[i]) begin
      if (dir_table[i].op == ROW_ENABLE) begin
        write_enable(dir_table[i].enable);
      end else begin
        send_frame(dir_table[i].frame, dir_table[i].typed, dir_table[i].want);
      end
    end
    sent_seq[0] = 32'd651;

    run_traffic(500, 1'b1, 24, 84);
    run_traffic(200, 1'b0, 84, 24);
    run_traffic(300, 1'b1, 84, 24);
    run_traffic(400, 1'b1, 0, 0);

    drain_reports();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && ratio_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
